// ===== rtl/core/hcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, codes and helpers shared by the chunked body decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbd_pkg;

  localparam int unsigned SIZE_BITS_DEF = 32;
  localparam int unsigned RADIX_BITS    = 4;   // one hex digit

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  typedef enum logic [5:0] {
    PH_SIZE     = 6'b000001,
    PH_SKIP     = 6'b000010,
    PH_DATA     = 6'b000100,
    PH_AFTER    = 6'b001000,
    PH_AFTER_CR = 6'b010000,
    PH_DONE     = 6'b100000
  } phase_e;

  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_DONE     = 3'd1,
    ST_BAD_SIZE = 3'd2,
    ST_NO_LF    = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_TRUNC    = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic [2:0] status;
  } out_t;

  // control part of the decoder state
  typedef struct packed {
    phase_e  phase;
    logic    digit_seen;
    status_e status;
  } ctl_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t r;
    r.ok    = 1'b1;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.value = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.value = 4'(c - 8'h61 + 8'd10);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hcbd_step.sv =====
// ----------------------------------------------------------------------------
// hcbd_step
// Next-state and result logic of the decoder for one received word.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_step
  import hcbd_pkg::*;
#(
  parameter int unsigned SizeBits = SIZE_BITS_DEF
) (
  input  ctl_t                ctl_i,
  input  logic [SizeBits-1:0] acc_i,
  input  logic [SizeBits-1:0] left_i,
  input  in_t                 item_i,
  output ctl_t                ctl_o,
  output logic [SizeBits-1:0] acc_o,
  output logic [SizeBits-1:0] left_o,
  output out_t                res_o
);

  hex_t                hex;
  logic                acc_top_set;
  logic [SizeBits-1:0] one;

  assign hex         = hex_digit(item_i.in_byte);
  assign acc_top_set = |acc_i[SizeBits-1 -: RADIX_BITS];
  assign one         = {{(SizeBits-1){1'b0}}, 1'b1};

  always_comb begin
    ctl_o          = ctl_i;
    acc_o          = acc_i;
    left_o         = left_i;
    res_o.out_byte = 8'd0;
    res_o.out_valid = 1'b0;

    if (ctl_i.status != ST_BUSY) begin
      // done or error: word ignored
    end else if (item_i.stream_end) begin
      ctl_o.status = ST_TRUNC;
    end else begin
      case (ctl_i.phase)
        PH_SIZE, PH_SKIP: begin
          if (item_i.in_byte == CH_LF) begin
            // end of size line
            if (!ctl_i.digit_seen) begin
              ctl_o.status = ST_BAD_SIZE;
            end else if (acc_i == '0) begin
              ctl_o.phase  = PH_DONE;
              ctl_o.status = ST_DONE;
            end else begin
              left_o      = acc_i;
              ctl_o.phase = PH_DATA;
            end
          end else if (ctl_i.phase == PH_SKIP) begin
            // extension or trailing bytes skipped
          end else if (item_i.in_byte == CH_CR || item_i.in_byte == CH_SEMI) begin
            ctl_o.phase = PH_SKIP;
          end else if (!hex.ok) begin
            ctl_o.status = ST_BAD_SIZE;
          end else if (acc_top_set) begin
            ctl_o.status = ST_OVERFLOW;
          end else begin
            acc_o            = {acc_i[SizeBits-RADIX_BITS-1:0], hex.value};
            ctl_o.digit_seen = 1'b1;
          end
        end
        PH_DATA: begin
          res_o.out_byte  = item_i.in_byte;
          res_o.out_valid = 1'b1;
          left_o          = left_i - one;
          if (left_i == one) begin
            ctl_o.phase = PH_AFTER;
          end
        end
        PH_AFTER: begin
          if (item_i.in_byte == CH_CR) begin
            ctl_o.phase = PH_AFTER_CR;
          end else if (item_i.in_byte == CH_LF) begin
            ctl_o.phase      = PH_SIZE;
            ctl_o.digit_seen = 1'b0;
            acc_o            = '0;
          end else begin
            ctl_o.status = ST_NO_LF;
          end
        end
        PH_AFTER_CR: begin
          if (item_i.in_byte == CH_LF) begin
            ctl_o.phase      = PH_SIZE;
            ctl_o.digit_seen = 1'b0;
            acc_o            = '0;
          end else begin
            ctl_o.status = ST_NO_LF;
          end
        end
        default: begin
        end
      endcase
    end

    res_o.status = ctl_o.status;
  end

endmodule

`default_nettype wire

// ===== rtl/core/http_chunked_body_decoder.sv =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes an HTTP/1.1 chunked body one byte per word, one result per word.
// ----------------------------------------------------------------------------
// path: an accepted word waits in the input register, is decoded, and its result
//   is held in the result register for as long as out_ready_i is low
// throughput: one word per cycle unless out_ready_i stalls the result register,
//   set by the single decode step between the input and result registers
// reset: control state and decoder state cleared asynchronously; no memories
`default_nettype none

module http_chunked_body_decoder
  import hcbd_pkg::*;
#(
  parameter int unsigned SizeBits = SIZE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic                s1_valid_q, s1_valid_d;
  in_t                 s1_item_q;
  logic                s1_adv;
  logic                out_valid_q, out_valid_d;
  out_t                out_data_q;

  ctl_t                ctl_q, ctl_d;
  logic [SizeBits-1:0] acc_q, acc_d;
  logic [SizeBits-1:0] left_q, left_d;
  out_t                res;

  // whole pipe moves when the result register is free or being drained
  assign s1_adv      = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign s1_valid_d  = in_ready_o ? in_valid_i : s1_valid_q;
  assign out_valid_d = s1_adv ? s1_valid_q : out_valid_q;

  hcbd_step #(
    .SizeBits(SizeBits)
  ) u_step (
    .ctl_i (ctl_q),
    .acc_i (acc_q),
    .left_i(left_q),
    .item_i(s1_item_q),
    .ctl_o (ctl_d),
    .acc_o (acc_d),
    .left_o(left_d),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q       <= 1'b0;
      out_valid_q      <= 1'b0;
      ctl_q.phase      <= PH_SIZE;
      ctl_q.digit_seen <= 1'b0;
      ctl_q.status     <= ST_BUSY;
      acc_q            <= '0;
      left_q           <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_valid_q && s1_adv) begin
        ctl_q  <= ctl_d;
        acc_q  <= acc_d;
        left_q <= left_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_data_i;
    end
    if (s1_valid_q && s1_adv) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // payload only goes out while the stream is still busy
  a_payload_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_valid |-> out_data_o.status == ST_BUSY)
    else $error("payload word with non-busy status");

  // done and error codes are sticky
  a_status_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q.status != ST_BUSY |=> ctl_q.status == $past(ctl_q.status))
    else $error("sticky status changed");

  // a data phase always has bytes to go
  a_data_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q.phase == PH_DATA && ctl_q.status == ST_BUSY |-> left_q != '0)
    else $error("data phase with zero bytes left");

  // a stalled result keeps the input stage from dropping its word
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_item_q))
    else $error("input stage lost a word under stall");

endmodule

`default_nettype wire
